// ===== design/hexcan_pkg.sv =====
// package of types, constants and helpers for the hex text can frame parser
package hexcan_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned ID_W      = 12;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned NIBBLES   = DATA_W / 4;
  localparam int unsigned KNOWN_IDS = 19;

  // output word: id, data, count and five flags, padded to whole bytes
  localparam int unsigned OUT_BITS = ID_W + DATA_W + COUNT_W + 5;
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [CHAR_W-1:0] DELIM_CHAR = 8'h23;
  localparam logic [POS_W-1:0]  POS_DELIM  = 8'd3;
  localparam logic [POS_W-1:0]  POS_DATA   = 8'd4;
  localparam logic [POS_W-1:0]  POS_MAX    = 8'd255;

  typedef logic [ID_W-1:0] can_id_t;

  localparam can_id_t ID_TABLE [KNOWN_IDS] = '{
    12'h050, 12'h280, 12'h320, 12'h420, 12'h470, 12'h520, 12'h531, 12'h621,
    12'h635, 12'h727, 12'h1A0, 12'h3D0, 12'h52A, 12'h5A0, 12'h5C1, 12'h5D2,
    12'h60E, 12'h62E, 12'h0C2
  };

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } nibble_t;

  typedef struct packed {
    logic          id_allowed;
    logic          overflow;
    logic          too_short;
    logic          bad_hex;
    logic          delimiter_error;
    logic [COUNT_W-1:0] byte_count;
    logic [DATA_W-1:0]  data_bytes;
    can_id_t       can_id;
  } frame_t;

  function automatic nibble_t hex_decode(input logic [CHAR_W-1:0] c);
    nibble_t n;
    n.ok  = 1'b1;
    n.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      n.val = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      n.val = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      n.val = 4'(c - 8'h57);
    end else begin
      n.ok = 1'b0;
    end
    return n;
  endfunction

endpackage

// ===== design/hex_text_can_frame_parser.sv =====
// top level of the hex text can frame parser
// Takes one ASCII character per cycle: three hex id digits, a '#', then hex digit
// pairs for up to MAX_DATA_BYTES data bytes. Each word updates the frame state in
// the cycle it is accepted; the word marked tlast loads the output register, so the
// frame result appears in the cycle after it and the next frame may start right away.
// The only stall comes from the single output register: while a result waits
// there and m_axis_tready is low, s_axis_tready is low too.
module hex_text_can_frame_parser #(
  parameter int unsigned MAX_DATA_BYTES = 8,
  parameter int unsigned ALLOWLIST_SIZE = 19
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // char_in
  input  logic                           s_axis_tlast,   // last_char
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // can_id, data_bytes, byte_count, delimiter_error, bad_hex, too_short,
  // overflow, id_allowed, zero pad
  output logic [hexcan_pkg::OUT_W-1:0]   m_axis_tdata
);

  localparam int unsigned CHECK_N =
    (ALLOWLIST_SIZE < hexcan_pkg::KNOWN_IDS) ? ALLOWLIST_SIZE : hexcan_pkg::KNOWN_IDS;
  localparam int unsigned DATA_NIB = 2 * MAX_DATA_BYTES;

  logic [hexcan_pkg::POS_W-1:0]  pos_q, pos_d;
  hexcan_pkg::can_id_t           id_q, id_d;
  logic [hexcan_pkg::DATA_W-1:0] data_q, data_d;
  logic                          delim_q, delim_d;
  logic                          hex_q, hex_d;
  logic                          ovf_q, ovf_d;

  logic                          out_valid_q;
  hexcan_pkg::frame_t            out_q;
  hexcan_pkg::frame_t            frame;

  logic                          accept;
  hexcan_pkg::nibble_t           nib;
  logic [hexcan_pkg::POS_W-1:0]  dig_idx;
  logic [hexcan_pkg::POS_W-1:0]  half_cnt;
  logic                          allowed;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign nib           = hexcan_pkg::hex_decode(s_axis_tdata);
  assign dig_idx       = pos_q - hexcan_pkg::POS_DATA;

  // per character state update
  always_comb begin
    id_d    = id_q;
    data_d  = data_q;
    delim_d = delim_q;
    hex_d   = hex_q;
    ovf_d   = ovf_q;
    if (pos_q < hexcan_pkg::POS_DELIM) begin
      id_d  = {id_q[hexcan_pkg::ID_W-5:0], nib.val};
      hex_d = hex_q || !nib.ok;
    end else if (pos_q == hexcan_pkg::POS_DELIM) begin
      delim_d = delim_q || (s_axis_tdata != hexcan_pkg::DELIM_CHAR);
    end else begin
      hex_d = hex_q || !nib.ok;
      if (dig_idx >= hexcan_pkg::POS_W'(DATA_NIB)) begin
        ovf_d = 1'b1;
      end
      for (int k = 0; k < hexcan_pkg::NIBBLES; k++) begin
        if (k < DATA_NIB && dig_idx == hexcan_pkg::POS_W'(k ^ 1)) begin
          data_d[4*k +: 4] = data_q[4*k +: 4] | nib.val;
        end
      end
    end
    pos_d = (pos_q == hexcan_pkg::POS_MAX) ? pos_q : pos_q + hexcan_pkg::POS_W'(1);
  end

  // allowlist match on the final identifier
  always_comb begin
    allowed = 1'b0;
    for (int i = 0; i < CHECK_N; i++) begin
      if (id_d == hexcan_pkg::ID_TABLE[i]) begin
        allowed = 1'b1;
      end
    end
  end

  // result of the frame ending with this character
  always_comb begin
    half_cnt = (pos_q - 8'd2) >> 1;
    frame.can_id          = id_d;
    frame.data_bytes      = data_d;
    frame.delimiter_error = delim_d;
    frame.bad_hex         = hex_d;
    frame.too_short       = pos_q < hexcan_pkg::POS_DELIM;
    frame.overflow        = ovf_d;
    frame.id_allowed      = allowed;
    if (pos_q < hexcan_pkg::POS_DATA) begin
      frame.byte_count = '0;
    end else if (half_cnt > hexcan_pkg::POS_W'(MAX_DATA_BYTES)) begin
      frame.byte_count = hexcan_pkg::COUNT_W'(MAX_DATA_BYTES);
    end else begin
      frame.byte_count = half_cnt[hexcan_pkg::COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      id_q    <= '0;
      data_q  <= '0;
      delim_q <= 1'b0;
      hex_q   <= 1'b0;
      ovf_q   <= 1'b0;
    end else if (accept) begin
      if (s_axis_tlast) begin
        pos_q   <= '0;
        id_q    <= '0;
        data_q  <= '0;
        delim_q <= 1'b0;
        hex_q   <= 1'b0;
        ovf_q   <= 1'b0;
      end else begin
        pos_q   <= pos_d;
        id_q    <= id_d;
        data_q  <= data_d;
        delim_q <= delim_d;
        hex_q   <= hex_d;
        ovf_q   <= ovf_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && s_axis_tlast) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && s_axis_tlast) begin
      out_q <= frame;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = hexcan_pkg::OUT_W'(out_q);

endmodule
